[rtl/sbx_pkg.sv]
package sbx_pkg;

    localparam int ROUND_COUNT_DEF = 20;
    localparam int WORD_W          = 32;
    localparam int FIELD_W         = 64;
    localparam int DATA_FIELDS     = 8;
    localparam int CFG_INDEX_W     = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_01 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_23 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_45 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_67 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_NONCE  = 3'd4;

    localparam logic [WORD_W-1:0] SIGMA_0 = 32'h61707865;
    localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320646e;
    localparam logic [WORD_W-1:0] SIGMA_2 = 32'h79622d32;
    localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b206574;

    typedef logic [15:0][WORD_W-1:0] sbx_matrix_t;

    typedef struct packed {
        logic [FIELD_W-1:0] key_01;
        logic [FIELD_W-1:0] key_23;
        logic [FIELD_W-1:0] key_45;
        logic [FIELD_W-1:0] key_67;
        logic [FIELD_W-1:0] nonce;
    } sbx_cfg_t;

    typedef struct packed {
        sbx_matrix_t                         m;
        logic [FIELD_W-1:0]                  pos;
        logic [DATA_FIELDS-1:0][FIELD_W-1:0] data;
    } sbx_beat_t;

    function automatic logic [WORD_W-1:0] sbx_rotl(input logic [WORD_W-1:0] v, input int s);
        return (v << s) | (v >> (WORD_W - s));
    endfunction

    function automatic logic [3:0][WORD_W-1:0] sbx_quarter(
        input logic [WORD_W-1:0] a,
        input logic [WORD_W-1:0] b,
        input logic [WORD_W-1:0] c,
        input logic [WORD_W-1:0] d
    );
        logic [WORD_W-1:0] t;
        logic [WORD_W-1:0] na;
        logic [WORD_W-1:0] nb;
        logic [WORD_W-1:0] nc;
        logic [WORD_W-1:0] nd;
        t  = a + d;
        nb = b ^ sbx_rotl(t, 7);
        t  = nb + a;
        nc = c ^ sbx_rotl(t, 9);
        t  = nc + nb;
        nd = d ^ sbx_rotl(t, 13);
        t  = nd + nc;
        na = a ^ sbx_rotl(t, 18);
        return {nd, nc, nb, na};
    endfunction

    function automatic sbx_matrix_t sbx_round_f(input sbx_matrix_t m, input logic is_col);
        sbx_matrix_t             r;
        logic [3:0][WORD_W-1:0]  q0;
        logic [3:0][WORD_W-1:0]  q1;
        logic [3:0][WORD_W-1:0]  q2;
        logic [3:0][WORD_W-1:0]  q3;
        r = m;
        if (is_col)
        begin
            q0 = sbx_quarter(m[0],  m[4],  m[8],  m[12]);
            q1 = sbx_quarter(m[5],  m[9],  m[13], m[1]);
            q2 = sbx_quarter(m[10], m[14], m[2],  m[6]);
            q3 = sbx_quarter(m[15], m[3],  m[7],  m[11]);
            r[0]  = q0[0]; r[4]  = q0[1]; r[8]  = q0[2]; r[12] = q0[3];
            r[5]  = q1[0]; r[9]  = q1[1]; r[13] = q1[2]; r[1]  = q1[3];
            r[10] = q2[0]; r[14] = q2[1]; r[2]  = q2[2]; r[6]  = q2[3];
            r[15] = q3[0]; r[3]  = q3[1]; r[7]  = q3[2]; r[11] = q3[3];
        end
        else
        begin
            q0 = sbx_quarter(m[0],  m[1],  m[2],  m[3]);
            q1 = sbx_quarter(m[5],  m[6],  m[7],  m[4]);
            q2 = sbx_quarter(m[10], m[11], m[8],  m[9]);
            q3 = sbx_quarter(m[15], m[12], m[13], m[14]);
            r[0]  = q0[0]; r[1]  = q0[1]; r[2]  = q0[2]; r[3]  = q0[3];
            r[5]  = q1[0]; r[6]  = q1[1]; r[7]  = q1[2]; r[4]  = q1[3];
            r[10] = q2[0]; r[11] = q2[1]; r[8]  = q2[2]; r[9]  = q2[3];
            r[15] = q3[0]; r[12] = q3[1]; r[13] = q3[2]; r[14] = q3[3];
        end
        return r;
    endfunction

    function automatic sbx_matrix_t sbx_init(input sbx_cfg_t cfg, input logic [FIELD_W-1:0] pos);
        sbx_matrix_t m;
        m[0]  = SIGMA_0;
        m[1]  = cfg.key_01[31:0];
        m[2]  = cfg.key_01[63:32];
        m[3]  = cfg.key_23[31:0];
        m[4]  = cfg.key_23[63:32];
        m[5]  = SIGMA_1;
        m[6]  = cfg.nonce[31:0];
        m[7]  = cfg.nonce[63:32];
        m[8]  = pos[31:0];
        m[9]  = pos[63:32];
        m[10] = SIGMA_2;
        m[11] = cfg.key_45[31:0];
        m[12] = cfg.key_45[63:32];
        m[13] = cfg.key_67[31:0];
        m[14] = cfg.key_67[63:32];
        m[15] = SIGMA_3;
        return m;
    endfunction

endpackage

[rtl/salsa20_block_xor_top.sv]
// Salsa20 block xor engine. Each input beat carries a 64-bit block position and
// 64 data bytes; the beat out is the data xored with the Salsa20 keystream block
// for the configured 256-bit key and 64-bit nonce at that position, so the same
// engine encrypts and decrypts. One beat is accepted per cycle and one result
// leaves per cycle while m_axis_tready is high; the pipeline holds one register
// stage per round (four quarter-rounds side by side) plus the output stage that
// adds the input matrix back and applies the xor. Write key and nonce only while
// no beat is in flight.
module salsa20_block_xor_top #(
    parameter int ROUND_COUNT = sbx_pkg::ROUND_COUNT_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [sbx_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [sbx_pkg::FIELD_W-1:0]           cfg_wdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // block_position, data_bytes_0_7, data_bytes_8_15 .. data_bytes_56_63
    input  logic [(sbx_pkg::DATA_FIELDS+1)*sbx_pkg::FIELD_W-1:0] s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // out_bytes_0_7, out_bytes_8_15 .. out_bytes_56_63
    output logic [sbx_pkg::DATA_FIELDS*sbx_pkg::FIELD_W-1:0] m_axis_tdata
);

    sbx_pkg::sbx_cfg_t  cfg_reg;
    sbx_pkg::sbx_beat_t beat   [ROUND_COUNT+1];
    logic               valid  [ROUND_COUNT+1];
    logic               ready  [ROUND_COUNT+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sbx_pkg::CFG_KEY_01: cfg_reg.key_01 <= cfg_wdata;
                sbx_pkg::CFG_KEY_23: cfg_reg.key_23 <= cfg_wdata;
                sbx_pkg::CFG_KEY_45: cfg_reg.key_45 <= cfg_wdata;
                sbx_pkg::CFG_KEY_67: cfg_reg.key_67 <= cfg_wdata;
                sbx_pkg::CFG_NONCE:  cfg_reg.nonce  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        beat[0].pos  = s_axis_tdata[sbx_pkg::FIELD_W-1:0];
        beat[0].data = s_axis_tdata[(sbx_pkg::DATA_FIELDS+1)*sbx_pkg::FIELD_W-1:sbx_pkg::FIELD_W];
        beat[0].m    = sbx_pkg::sbx_init(cfg_reg, s_axis_tdata[sbx_pkg::FIELD_W-1:0]);
    end

    assign valid[0]      = s_axis_tvalid;
    assign s_axis_tready = ready[0];

    for (genvar r = 0; r < ROUND_COUNT; r++)
    begin : g_round
        sbx_round #(
            .IS_COLUMN ((r % 2) == 0)
        ) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid[r]),
            .in_ready  (ready[r]),
            .in_beat   (beat[r]),
            .out_valid (valid[r+1]),
            .out_ready (ready[r+1]),
            .out_beat  (beat[r+1])
        );
    end

    sbx_final u_final (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (valid[ROUND_COUNT]),
        .in_ready  (ready[ROUND_COUNT]),
        .in_beat   (beat[ROUND_COUNT]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

[rtl/sbx_round.sv]
module sbx_round #(
    parameter logic IS_COLUMN = 1'b1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sbx_pkg::sbx_beat_t in_beat,
    output logic              out_valid,
    input  logic              out_ready,
    output sbx_pkg::sbx_beat_t out_beat
);

    logic               valid_reg;
    sbx_pkg::sbx_beat_t beat_reg;
    sbx_pkg::sbx_beat_t beat_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    always_comb
    begin
        beat_next   = in_beat;
        beat_next.m = sbx_pkg::sbx_round_f(in_beat.m, IS_COLUMN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            beat_reg <= beat_next;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |=> (valid_reg && $stable(beat_reg)))
        else $error("round stage lost or changed a stalled beat");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> valid_reg)
        else $error("round stage dropped an accepted beat");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> in_ready)
        else $error("empty round stage refuses a beat");

endmodule

[rtl/sbx_final.sv]
module sbx_final (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  sbx_pkg::sbx_cfg_t                             cfg,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  sbx_pkg::sbx_beat_t                            in_beat,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [sbx_pkg::DATA_FIELDS*sbx_pkg::FIELD_W-1:0] out_data
);

    logic                                                    valid_reg;
    logic [sbx_pkg::DATA_FIELDS-1:0][sbx_pkg::FIELD_W-1:0]   data_reg;
    logic [sbx_pkg::DATA_FIELDS-1:0][sbx_pkg::FIELD_W-1:0]   data_next;
    sbx_pkg::sbx_matrix_t                                    init_m;
    sbx_pkg::sbx_matrix_t                                    ks;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        init_m = sbx_pkg::sbx_init(cfg, in_beat.pos);
        for (int w = 0; w < 16; w++)
        begin
            ks[w] = in_beat.m[w] + init_m[w];
        end
        for (int j = 0; j < sbx_pkg::DATA_FIELDS; j++)
        begin
            data_next[j] = in_beat.data[j] ^ {ks[2*j+1], ks[2*j]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |=> (valid_reg && $stable(data_reg)))
        else $error("output stage lost or changed a stalled beat");

    a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> valid_reg)
        else $error("output stage dropped an accepted beat");

    a_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> in_ready)
        else $error("empty output stage refuses a beat");

endmodule

[tb/tb_salsa20_block_xor_top.sv]
module tb_salsa20_block_xor_top;

    typedef logic [sbx_pkg::CFG_INDEX_W-1:0] idx_t;
    typedef logic [sbx_pkg::FIELD_W-1:0] field_t;
    typedef logic [sbx_pkg::DATA_FIELDS-1:0][sbx_pkg::FIELD_W-1:0] blk_t;

    localparam int ROUNDS         = sbx_pkg::ROUND_COUNT_DEF;
    localparam int TAIL_CYCLES    = ROUNDS + 10;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 400;
    localparam int NUM_PHASES     = 6;
    localparam int PHASE_ITEMS    = 300;
    localparam int MAX_REPORTS    = 10;

    localparam idx_t CFG_SPARE = idx_t'(sbx_pkg::CFG_NONCE + 1);
    localparam idx_t CFG_TOP   = '1;

    typedef enum logic {
        ROW_BEAT,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        idx_t                    index;
        field_t                  value;
        blk_t                    data;
    } row_t;

    logic                                                  clk;
    logic                                                  rst_n;
    logic                                                  cfg_we;
    idx_t                                                  cfg_index;
    field_t                                                cfg_wdata;
    logic                                                  s_axis_tvalid;
    logic                                                  s_axis_tready;
    logic [(sbx_pkg::DATA_FIELDS+1)*sbx_pkg::FIELD_W-1:0]  s_axis_tdata;
    logic                                                  m_axis_tvalid;
    logic                                                  m_axis_tready;
    logic [sbx_pkg::DATA_FIELDS*sbx_pkg::FIELD_W-1:0]      m_axis_tdata;

    field_t key_01;
    field_t key_23;
    field_t key_45;
    field_t key_67;
    field_t nonce_w;
    field_t stream_pos;

    blk_t   xored_q [$];
    row_t   dir_rows [$];
    int     err_cnt;
    int     idle_cycles;
    int     stall_left;
    bit     tx_quiet;
    bit     hold_req;
    bit     hold_done;

    salsa20_block_xor_top #(
        .ROUND_COUNT (ROUNDS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] rot_left(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic logic [127:0] quarter_round(
        input logic [31:0] a,
        input logic [31:0] b,
        input logic [31:0] c,
        input logic [31:0] d
    );
        b = b ^ rot_left(a + d, 7);
        c = c ^ rot_left(b + a, 9);
        d = d ^ rot_left(c + b, 13);
        a = a ^ rot_left(d + c, 18);
        return {a, b, c, d};
    endfunction

    function automatic blk_t salsa_xor(input field_t pos, input blk_t din);
        logic [31:0] s [16];
        logic [31:0] x [16];
        blk_t        dout;
        s[0]  = sbx_pkg::SIGMA_0;
        s[1]  = key_01[31:0];
        s[2]  = key_01[63:32];
        s[3]  = key_23[31:0];
        s[4]  = key_23[63:32];
        s[5]  = sbx_pkg::SIGMA_1;
        s[6]  = nonce_w[31:0];
        s[7]  = nonce_w[63:32];
        s[8]  = pos[31:0];
        s[9]  = pos[63:32];
        s[10] = sbx_pkg::SIGMA_2;
        s[11] = key_45[31:0];
        s[12] = key_45[63:32];
        s[13] = key_67[31:0];
        s[14] = key_67[63:32];
        s[15] = sbx_pkg::SIGMA_3;
        for (int j = 0; j < 16; j++)
        begin
            x[j] = s[j];
        end
        for (int r = 0; r < ROUNDS; r++)
        begin
            if (r % 2 == 0)
            begin
                {x[0],  x[4],  x[8],  x[12]} = quarter_round(x[0],  x[4],  x[8],  x[12]);
                {x[5],  x[9],  x[13], x[1]}  = quarter_round(x[5],  x[9],  x[13], x[1]);
                {x[10], x[14], x[2],  x[6]}  = quarter_round(x[10], x[14], x[2],  x[6]);
                {x[15], x[3],  x[7],  x[11]} = quarter_round(x[15], x[3],  x[7],  x[11]);
            end
            else
            begin
                {x[0],  x[1],  x[2],  x[3]}  = quarter_round(x[0],  x[1],  x[2],  x[3]);
                {x[5],  x[6],  x[7],  x[4]}  = quarter_round(x[5],  x[6],  x[7],  x[4]);
                {x[10], x[11], x[8],  x[9]}  = quarter_round(x[10], x[11], x[8],  x[9]);
                {x[15], x[12], x[13], x[14]} = quarter_round(x[15], x[12], x[13], x[14]);
            end
        end
        for (int j = 0; j < sbx_pkg::DATA_FIELDS; j++)
        begin
            dout[j] = din[j] ^ {x[2*j+1] + s[2*j+1], x[2*j] + s[2*j]};
        end
        return dout;
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic field_t rnd_field();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic blk_t rnd_block();
        blk_t b;
        for (int j = 0; j < sbx_pkg::DATA_FIELDS; j++)
        begin
            b[j] = rnd_field();
        end
        return b;
    endfunction

    function automatic blk_t fill_blk(input field_t v);
        blk_t b;
        for (int j = 0; j < sbx_pkg::DATA_FIELDS; j++)
        begin
            b[j] = v;
        end
        return b;
    endfunction

    // mostly consecutive positions, with restarts near the word boundaries or at random, and stray random positions
    function automatic field_t next_pos();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            stream_pos = stream_pos + 1;
            return stream_pos;
        end
        if (r < 76)
        begin
            case ($urandom_range(0, 2))
                0:       stream_pos = 64'h0000_0000_FFFF_FFFD;
                1:       stream_pos = 64'hFFFF_FFFF_FFFF_FFFD;
                default: stream_pos = {$urandom, $urandom};
            endcase
            return stream_pos;
        end
        return rnd_field();
    endfunction

    function automatic void add_beat(input field_t pos, input blk_t d);
        row_t r;
        r.kind  = ROW_BEAT;
        r.index = '0;
        r.value = pos;
        r.data  = d;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_cfg(input idx_t idx, input field_t v);
        row_t r;
        r.kind  = ROW_CFG;
        r.index = idx;
        r.value = v;
        r.data  = '0;
        dir_rows.push_back(r);
    endfunction

    task automatic write_reg(input idx_t idx, input field_t val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            sbx_pkg::CFG_KEY_01: key_01  = val;
            sbx_pkg::CFG_KEY_23: key_23  = val;
            sbx_pkg::CFG_KEY_45: key_45  = val;
            sbx_pkg::CFG_KEY_67: key_67  = val;
            sbx_pkg::CFG_NONCE:  nonce_w = val;
            default:             ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // drop valid and wait for every pending beat to come out
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (xored_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_beat(input field_t pos, input blk_t data);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {data, pos};
        do
            @(posedge clk);
        while (!s_axis_tready);
        xored_q.push_back(salsa_xor(pos, data));
    endtask

    task automatic setup_phase(input int p);
        field_t v [5];
        for (int k = 0; k < 5; k++)
        begin
            case (p)
                0:       v[k] = '0;
                1:       v[k] = '1;
                default: v[k] = rnd_field();
            endcase
        end
        drain();
        write_reg(sbx_pkg::CFG_KEY_01, v[0]);
        write_reg(sbx_pkg::CFG_KEY_23, v[1]);
        write_reg(sbx_pkg::CFG_KEY_45, v[2]);
        write_reg(sbx_pkg::CFG_KEY_67, v[3]);
        write_reg(sbx_pkg::CFG_NONCE, v[4]);
        write_reg(idx_t'($urandom_range(CFG_SPARE, CFG_TOP)), rnd_field());
    endtask

    initial
    begin
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_done = 1'b1;
                m_axis_tready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : out_check
        blk_t got;
        blk_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (xored_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("unexpected beat: %h", got);
            end
            else
            begin
                want = xored_q.pop_front();
                for (int j = 0; j < sbx_pkg::DATA_FIELDS; j++)
                begin
                    if (got[j] !== want[j])
                    begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                            $display("out_bytes field %0d: expected %h, got %h",
                                     j, want[j], got[j]);
                    end
                end
            end
        end
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        row_t row;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        key_01        = '0;
        key_23        = '0;
        key_45        = '0;
        key_67        = '0;
        nonce_w       = '0;
        stream_pos    = '0;
        err_cnt       = 0;
        idle_cycles   = 0;
        tx_quiet      = 1'b0;
        hold_req      = 1'b0;
        hold_done     = 1'b0;

        add_beat('0, fill_blk('0));
        add_beat('1, fill_blk('1));
        add_beat(64'h0000_0000_FFFF_FFFF, fill_blk(64'h0123_4567_89AB_CDEF));
        add_beat(64'h0000_0001_0000_0000, fill_blk(64'hFEDC_BA98_7654_3210));
        add_cfg(sbx_pkg::CFG_KEY_01, '1);
        add_cfg(sbx_pkg::CFG_KEY_23, '1);
        add_cfg(sbx_pkg::CFG_KEY_45, '1);
        add_cfg(sbx_pkg::CFG_KEY_67, '1);
        add_cfg(sbx_pkg::CFG_NONCE, '1);
        add_beat('0, fill_blk('0));
        add_beat('1, fill_blk('1));
        // writes to unused indexes must leave the key alone
        add_cfg(CFG_SPARE, '0);
        add_cfg(CFG_TOP, '0);
        add_beat(64'h5, fill_blk('0));
        add_cfg(sbx_pkg::CFG_KEY_01, 64'h5555_5555_5555_5555);
        add_cfg(sbx_pkg::CFG_KEY_23, 64'hAAAA_AAAA_AAAA_AAAA);
        add_cfg(sbx_pkg::CFG_KEY_45, '0);
        add_cfg(sbx_pkg::CFG_KEY_67, 64'h8000_0000_0000_0001);
        add_cfg(sbx_pkg::CFG_NONCE, 64'h0000_0001_FFFF_FFFF);
        add_beat(64'h1, fill_blk(64'hAAAA_AAAA_AAAA_AAAA));
        add_beat(64'h8000_0000_0000_0000, fill_blk(64'h5555_5555_5555_5555));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG)
            begin
                drain();
                write_reg(row.index, row.value);
            end
            else
            begin
                send_beat(row.value, row.data);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            setup_phase(p);
            tx_quiet = (p == 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 2 && n == 40)
                    hold_req = 1'b1;
                if (p == 3 && n == 150)
                    drain();
                send_beat(next_pos(), rnd_block());
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        err_cnt += xored_q.size();
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[salsa20_block_xor_top.f]
rtl/sbx_pkg.sv
rtl/sbx_round.sv
rtl/sbx_final.sv
rtl/salsa20_block_xor_top.sv
tb/tb_salsa20_block_xor_top.sv
